### hw/rtl/uvnc_pkg.sv
// Package for the UTF-8 validator without combining marks.
// Holds the lead byte ranges, the code point limits and the code point check.
// No dependencies.
`timescale 1ns / 1ps

package uvnc_pkg;

   localparam int unsigned CP_W = 21;

   typedef logic [CP_W-1:0] cp_type;
   typedef logic [2:0]      seq_width_type;
   typedef logic [1:0]      pend_type;

   // sequence lengths
   localparam seq_width_type SEQ_NONE = 3'd0;
   localparam seq_width_type SEQ_ONE  = 3'd1;
   localparam seq_width_type SEQ_TWO  = 3'd2;
   localparam seq_width_type SEQ_THR  = 3'd3;
   localparam seq_width_type SEQ_FOUR = 3'd4;

   // lead byte ranges
   localparam logic [7:0] LEAD1_MAX = 8'h7F;
   localparam logic [7:0] LEAD2_MIN = 8'hC2;
   localparam logic [7:0] LEAD2_MAX = 8'hDF;
   localparam logic [7:0] LEAD3_MIN = 8'hE0;
   localparam logic [7:0] LEAD3_MAX = 8'hEF;
   localparam logic [7:0] LEAD4_MIN = 8'hF0;
   localparam logic [7:0] LEAD4_MAX = 8'hF4;

   localparam logic [1:0] CONT_TAG = 2'b10;

   // code point limits
   localparam cp_type MIN_TWO    = 21'h000080;
   localparam cp_type MIN_THR    = 21'h000800;
   localparam cp_type MIN_FOUR   = 21'h010000;
   localparam cp_type MAX_POINT  = 21'h10FFFF;
   localparam cp_type SURR_LO    = 21'h00D800;
   localparam cp_type SURR_HI    = 21'h00DFFF;
   localparam cp_type COMB1_LO   = 21'h000300;
   localparam cp_type COMB1_HI   = 21'h00036F;
   localparam cp_type COMB2_LO   = 21'h001AB0;
   localparam cp_type COMB2_HI   = 21'h001AFF;
   localparam cp_type COMB3_LO   = 21'h001DC0;
   localparam cp_type COMB3_HI   = 21'h001DFF;
   localparam cp_type COMB4_LO   = 21'h0020D0;
   localparam cp_type COMB4_HI   = 21'h0020FF;
   localparam cp_type COMB5_LO   = 21'h00FE20;
   localparam cp_type COMB5_HI   = 21'h00FE2F;

   // true when a completed code point of the given length is acceptable
   function automatic logic point_ok(input seq_width_type width, input cp_type p);
      logic ok;
      ok = 1'b1;
      if (width == SEQ_TWO  && p < MIN_TWO)  ok = 1'b0;
      if (width == SEQ_THR  && p < MIN_THR)  ok = 1'b0;
      if (width == SEQ_FOUR && p < MIN_FOUR) ok = 1'b0;
      if (p > MAX_POINT) ok = 1'b0;
      if (p >= SURR_LO  && p <= SURR_HI)  ok = 1'b0;
      if (p >= COMB1_LO && p <= COMB1_HI) ok = 1'b0;
      if (p >= COMB2_LO && p <= COMB2_HI) ok = 1'b0;
      if (p >= COMB3_LO && p <= COMB3_HI) ok = 1'b0;
      if (p >= COMB4_LO && p <= COMB4_HI) ok = 1'b0;
      if (p >= COMB5_LO && p <= COMB5_HI) ok = 1'b0;
      return ok;
   endfunction

endpackage

### hw/rtl/utf8_validator_no_combining.sv
// Output: the verdict of a string is registered and is valid from the edge that transfers its last byte.
// Throughput: one byte per cycle; the decode state and the result register sit in the
// same single stage, so the input stalls only while a result waits and rsp_stall is high.
// Reset: synchronous, active high; clears the decode state, the error flag and the
// result valid.
// Strict UTF-8 check that also rejects combining marks; uses uvnc_pkg.
`timescale 1ns / 1ps

module utf8_validator_no_combining
   import uvnc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res
);

   pend_type      pend_ff,  pend_in;
   seq_width_type width_ff, width_in;
   cp_type        accum_ff, accum_in;
   logic          err_ff,   err_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_res_ff,   rsp_res_in;

   logic          req_xfer;
   logic          rsp_xfer;
   pend_type      pend_dec;
   seq_width_type width_dec;
   cp_type        accum_dec;
   logic          err_dec;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // decode one byte against the open sequence
   always_comb begin
      pend_dec  = pend_ff;
      width_dec = width_ff;
      accum_dec = accum_ff;
      err_dec   = err_ff;
      if (pend_ff == 2'd0) begin
         if (req_data_byte <= LEAD1_MAX) begin
            width_dec = SEQ_ONE;
            accum_dec = cp_type'(req_data_byte);
            pend_dec  = 2'd0;
            if (!point_ok(SEQ_ONE, accum_dec)) err_dec = 1'b1;
         end else if (req_data_byte >= LEAD2_MIN && req_data_byte <= LEAD2_MAX) begin
            width_dec = SEQ_TWO;
            accum_dec = cp_type'(req_data_byte[4:0]);
            pend_dec  = 2'd1;
         end else if (req_data_byte >= LEAD3_MIN && req_data_byte <= LEAD3_MAX) begin
            width_dec = SEQ_THR;
            accum_dec = cp_type'(req_data_byte[3:0]);
            pend_dec  = 2'd2;
         end else if (req_data_byte >= LEAD4_MIN && req_data_byte <= LEAD4_MAX) begin
            width_dec = SEQ_FOUR;
            accum_dec = cp_type'(req_data_byte[2:0]);
            pend_dec  = 2'd3;
         end else begin
            err_dec   = 1'b1;
            width_dec = SEQ_NONE;
            accum_dec = '0;
            pend_dec  = 2'd0;
         end
      end else if (req_data_byte[7:6] != CONT_TAG) begin
         // drop the open sequence; the next byte is read as a lead
         err_dec   = 1'b1;
         pend_dec  = 2'd0;
         width_dec = SEQ_NONE;
         accum_dec = '0;
      end else begin
         accum_dec = {accum_ff[CP_W-7:0], req_data_byte[5:0]};
         pend_dec  = pend_ff - 2'd1;
         if (pend_dec == 2'd0 && !point_ok(width_ff, accum_dec)) err_dec = 1'b1;
      end
   end

   always_comb begin
      pend_in      = pend_ff;
      width_in     = width_ff;
      accum_in     = accum_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (rsp_xfer) rsp_valid_in = 1'b0;
      if (req_xfer) begin
         if (req_last) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = !(err_dec || (pend_dec != 2'd0));
            pend_in      = 2'd0;
            width_in     = SEQ_NONE;
            accum_in     = '0;
            err_in       = 1'b0;
         end else begin
            pend_in  = pend_dec;
            width_in = width_dec;
            accum_in = accum_dec;
            err_in   = err_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 2'd0;
         width_ff     <= SEQ_NONE;
         accum_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         width_ff     <= width_in;
         accum_ff     <= accum_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   // a stall on the input only comes from a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled without a pending result");

   // a last byte leaves the decoder clean and a result ready
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_last) |=> (rsp_valid_ff && pend_ff == 2'd0 && !err_ff))
      else $error("state not cleared after last byte");

   // an open sequence always has a multi-byte width
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff != 2'd0) |-> (width_ff >= SEQ_TWO && width_ff <= SEQ_FOUR))
      else $error("pending bytes without multi-byte sequence");

   // a new result appears only after a last byte transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_xfer && req_last))
      else $error("result without last byte");

endmodule

### test/utf8_verdict_checker.sv
// Checker for the UTF-8 validator: watches both channels, decodes every byte
// transfer on its own and compares each verdict with the oldest one expected.
// Depends on uvnc_pkg for the sequence length codes.
`timescale 1ns / 1ps

module utf8_verdict_checker
   import uvnc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_valid_res,
   output int         fail_count,
   output int         pending_results
);

   pend_type      pend;
   seq_width_type width;
   cp_type        accum;
   logic          err;
   logic          want;
   logic          verdict_q [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   task automatic report(input string msg);
      $display("[%0t] %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic point_rejected(input seq_width_type w, input cp_type p);
      return (w == SEQ_TWO  && p < 21'h000080) ||
             (w == SEQ_THR  && p < 21'h000800) ||
             (w == SEQ_FOUR && p < 21'h010000) ||
             (p > 21'h10FFFF) ||
             (p >= 21'h00D800 && p <= 21'h00DFFF) ||
             (p >= 21'h000300 && p <= 21'h00036F) ||
             (p >= 21'h001AB0 && p <= 21'h001AFF) ||
             (p >= 21'h001DC0 && p <= 21'h001DFF) ||
             (p >= 21'h0020D0 && p <= 21'h0020FF) ||
             (p >= 21'h00FE20 && p <= 21'h00FE2F);
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic lst);
      if (pend == 2'd0) begin
         if (b <= 8'h7F) begin
            width = SEQ_ONE;
            accum = {13'd0, b};
         end else if (b >= 8'hC2 && b <= 8'hDF) begin
            width = SEQ_TWO;
            accum = {16'd0, b[4:0]};
            pend  = 2'd1;
         end else if (b >= 8'hE0 && b <= 8'hEF) begin
            width = SEQ_THR;
            accum = {17'd0, b[3:0]};
            pend  = 2'd2;
         end else if (b >= 8'hF0 && b <= 8'hF4) begin
            width = SEQ_FOUR;
            accum = {18'd0, b[2:0]};
            pend  = 2'd3;
         end else begin
            err   = 1'b1;
            width = SEQ_NONE;
            accum = '0;
         end
         if (width == SEQ_ONE && point_rejected(width, accum)) err = 1'b1;
      end else if (b[7:6] != 2'b10) begin
         // drop the open sequence; the next byte is read as a lead
         err   = 1'b1;
         pend  = 2'd0;
         width = SEQ_NONE;
         accum = '0;
      end else begin
         accum = {accum[14:0], b[5:0]};
         pend  = pend - 2'd1;
         if (pend == 2'd0 && point_rejected(width, accum)) err = 1'b1;
      end
      if (lst) begin
         if (pend != 2'd0) err = 1'b1;
         verdict_q.push_back(!err);
         pend  = 2'd0;
         width = SEQ_NONE;
         accum = '0;
         err   = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pend  = 2'd0;
         width = SEQ_NONE;
         accum = '0;
         err   = 1'b0;
         verdict_q.delete();
      end else begin
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_last);
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               report("verdict transfer with no string pending");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_valid_res !== want)
                  report($sformatf("valid_res mismatch: got %b, want %b", rsp_valid_res, want));
            end
         end
      end
      pending_results = verdict_q.size();
   end

endmodule

### test/tb_utf8_validator_no_combining.sv
// Top of the UTF-8 validator testbench: clock, reset, byte strings and result stalls.
// Depends on utf8_validator_no_combining, uvnc_pkg and utf8_verdict_checker.
`timescale 1ns / 1ps

module tb_utf8_validator_no_combining;

   localparam int STALL_LIMIT  = 200;
   localparam int BYTE_TARGET  = 950;
   localparam int NUM_BOUNDARY = 31;

   typedef logic [7:0] octet_q [$];

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_valid_res;
   int         fail_count;
   int         pending_results;
   int         quiet_cycles = 0;
   int         bytes_sent = 0;
   bit         idle_on = 1'b1;

   utf8_validator_no_combining dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res)
   );

   utf8_verdict_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // code points on either side of every limit and range edge, but only 10FFFF at the top limit
   function automatic logic [20:0] boundary_point(input int k);
      case (k)
         0:  return 21'h00007F;  1:  return 21'h000080;  2:  return 21'h0007FF;
         3:  return 21'h000800;  4:  return 21'h00FFFF;  5:  return 21'h010000;
         6:  return 21'h10FFFF;  7:  return 21'h00D7FF;  8:  return 21'h00D800;
         9:  return 21'h00DFFF;  10: return 21'h00E000;  11: return 21'h0002FF;
         12: return 21'h000300;  13: return 21'h00036F;  14: return 21'h000370;
         15: return 21'h001AAF;  16: return 21'h001AB0;  17: return 21'h001AFF;
         18: return 21'h001B00;  19: return 21'h001DBF;  20: return 21'h001DC0;
         21: return 21'h001DFF;  22: return 21'h001E00;  23: return 21'h0020CF;
         24: return 21'h0020D0;  25: return 21'h0020FF;  26: return 21'h002100;
         27: return 21'h00FE1F;  28: return 21'h00FE20;  29: return 21'h00FE2F;
         default: return 21'h00FE30;
      endcase
   endfunction

   function automatic int min_width(input logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   function automatic void put_point(ref octet_q q, input logic [20:0] cp, input int n);
      case (n)
         1: q.push_back({1'b0, cp[6:0]});
         2: begin
            q.push_back({3'b110, cp[10:6]});
            q.push_back({2'b10, cp[5:0]});
         end
         3: begin
            q.push_back({4'b1110, cp[15:12]});
            q.push_back({2'b10, cp[11:6]});
            q.push_back({2'b10, cp[5:0]});
         end
         default: begin
            q.push_back({5'b11110, cp[20:18]});
            q.push_back({2'b10, cp[17:12]});
            q.push_back({2'b10, cp[11:6]});
            q.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic logic [20:0] pick_point();
      case ($urandom_range(0, 5))
         0: return 21'($urandom_range(0, 'h7F));
         1: return 21'($urandom_range('h80, 'h7FF));
         2: return 21'($urandom_range('h800, 'hFFFF));
         3: return 21'($urandom_range('h10000, 'h10FFFF));
         default: return 21'(boundary_point($urandom_range(0, NUM_BOUNDARY - 1))
                             + $urandom_range(0, 2) - 1);
      endcase
   endfunction

   // mostly well-formed strings; some with overlong or oversized forms,
   // stray bytes, a cut-off tail or a corrupted byte
   task automatic make_string(output octet_q s);
      int          style;
      logic [20:0] cp;
      s = {};
      style = $urandom_range(0, 9);
      repeat ($urandom_range(1, 4)) begin
         cp = pick_point();
         if (style == 7) begin
            if ($urandom_range(0, 1)) put_point(s, 21'($urandom_range(0, 'h1FFFFF)), 4);
            else put_point(s, cp, $urandom_range(min_width(cp), 4));
         end else begin
            if (style == 8 && $urandom_range(0, 1)) s.push_back(8'($urandom_range(0, 255)));
            put_point(s, cp, min_width(cp));
         end
      end
      if (style == 9) begin
         if ($urandom_range(0, 1) && s.size() > 1) void'(s.pop_back());
         else s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
      end
   endtask

   task automatic send_string(input octet_q s);
      int gap;
      foreach (s[i]) begin
         gap = idle_on ? $urandom_range(0, 7) : 0;
         @(negedge clock);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid     = 1'b1;
         req_data_byte = s[i];
         req_last      = (i == s.size() - 1);
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
   endtask

   // hold the sender until every verdict is back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin
      octet_q s;
      int     n_str;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_string('{8'h00});
      send_string('{8'h7F});
      send_string('{8'h80});                      // stray continuation as lead
      send_string('{8'hFF});                      // lead above F4
      send_string('{8'hC2, 8'h80});               // smallest two-byte point
      send_string('{8'hE0, 8'h80, 8'h80});        // overlong three-byte form
      send_string('{8'hF4, 8'h90, 8'h80, 8'h80}); // above 10FFFF
      send_string('{8'hED, 8'hA0, 8'h80});        // surrogate
      send_string('{8'hCC, 8'h80});               // combining mark
      send_string('{8'hE2, 8'h83});               // cut off by the last byte
      send_string('{8'hC3, 8'h41, 8'h42});        // broken continuation, then clean bytes
      drain();

      n_str = 0;
      while (bytes_sent < BYTE_TARGET) begin
         idle_on = ((n_str / 25) % 3) != 1;
         make_string(s);
         send_string(s);
         n_str++;
         if (n_str % 40 == 0) drain();
      end
      drain();
      repeat (4) @(posedge clock);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         hold = idle_on ? $urandom_range(0, 7) : 0;
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
